/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, held off while reset is high.
`define PN_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define PN_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/pn_pkg.sv */
// Shared types, constants and the permutation ROM of the 2D gradient noise pipeline.
`default_nettype none

package pn_pkg;

   // Field and datapath widths
   localparam int FRAC_W  = 16;   // fraction in unsigned Q0.16
   localparam int CELL_W  = 8;    // lattice cell index, wraps modulo 256
   localparam int DOT_W   = 20;   // signed Q16 dot products and blends
   localparam int FADE_W  = 17;   // fade weight in Q16, up to 1.0
   localparam int OUT_W   = 16;   // Q1.15 result

   // Pipeline depth from accepted transaction to result strobe
   localparam int LATENCY = 10;

   // 1/sqrt(2) in Q0.16
   localparam logic signed [FRAC_W:0] SCALE_Q16 = 17'sd46341;

   typedef logic [FRAC_W-1:0]        frac_type;
   typedef logic [CELL_W-1:0]        cell_type;
   typedef logic [FADE_W-1:0]        fade_type;
   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [OUT_W-1:0]  noise_type;

   // Gradient selected by the low three hash bits
   typedef enum logic [2:0] {
      GRAD_PXPZ,
      GRAD_NXPZ,
      GRAD_PXNZ,
      GRAD_NXNZ,
      GRAD_PX,
      GRAD_NX,
      GRAD_PZ,
      GRAD_NZ
   } grad_type;

   // Gradient codes of the four cell corners
   typedef struct packed {
      grad_type g00;
      grad_type g10;
      grad_type g01;
      grad_type g11;
   } corner_grad_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   // Permutation ROM lookup
   function automatic cell_type perm_lookup(input cell_type idx);
      return PERM_ROM[idx];
   endfunction

   // Dot product of the selected gradient with the corner offset
   function automatic dot_type grad_dot(input grad_type g, input dot_type dx,
                                        input dot_type dz);
      dot_type res;
      case (g)
         GRAD_PXPZ: res = dx + dz;
         GRAD_NXPZ: res = dz - dx;
         GRAD_PXNZ: res = dx - dz;
         GRAD_NXNZ: res = -dx - dz;
         GRAD_PX:   res = dx;
         GRAD_NX:   res = -dx;
         GRAD_PZ:   res = dz;
         GRAD_NZ:   res = -dz;
         default:   res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/pn_fade.sv */
// Three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 in Q16.
`default_nettype none

module pn_fade import pn_pkg::*; (
   input  logic     clock,
   input  frac_type t,
   output fade_type fade
);

   frac_type           t_ff;
   frac_type           t2_ff, t2_in;
   frac_type           t3_ff, t3_in;
   logic [20:0]        q_ff, q_in;
   fade_type           fade_ff, fade_in;

   logic [31:0]        sq_prod, cube_prod;
   logic [32:0]        sq_rnd, cube_rnd;
   logic [36:0]        fade_prod, fade_rnd;
   logic [20:0]        fade_full;

   // Square and round
   always_comb begin
      sq_prod = 32'(t) * 32'(t);
      sq_rnd  = 33'(sq_prod) + 33'd32768;
      t2_in   = sq_rnd[31:16];
   end

   // Cube and the quadratic factor 6t^2 - 15t + 10
   always_comb begin
      cube_prod = 32'(t2_ff) * 32'(t_ff);
      cube_rnd  = 33'(cube_prod) + 33'd32768;
      t3_in     = cube_rnd[31:16];
      q_in      = 21'(t2_ff) * 21'd6 + 21'd655360 - 21'(t_ff) * 21'd15;
   end

   // Final product, round and clip at 1.0
   always_comb begin
      fade_prod = 37'(t3_ff) * 37'(q_ff);
      fade_rnd  = fade_prod + 37'd32768;
      fade_full = fade_rnd[36:16];
      if (fade_full > 21'd65536) begin
         fade_in = 17'd65536;
      end else begin
         fade_in = fade_full[FADE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      q_ff    <= q_in;
      fade_ff <= fade_in;
   end

   assign fade = fade_ff;

endmodule

`default_nettype wire

/* rtl/core/pn_hash.sv */
// Two-stage corner hash through the permutation ROM, giving four gradient codes.
`default_nettype none

module pn_hash import pn_pkg::*; (
   input  logic            clock,
   input  cell_type        cx0,
   input  cell_type        cz0,
   output corner_grad_type grads
);

   cell_type        px0_ff, px0_in;
   cell_type        px1_ff, px1_in;
   cell_type        cz0_ff;
   corner_grad_type grads_ff, grads_in;

   cell_type        idx00, idx10, idx01, idx11;
   cell_type        h00, h10, h01, h11;

   // First level: permute the x cells
   always_comb begin
      px0_in = perm_lookup(cx0);
      px1_in = perm_lookup(CELL_W'(cx0 + 8'd1));
   end

   // Second level: add the z cells, permute again, keep the low three bits
   always_comb begin
      idx00 = CELL_W'(px0_ff + cz0_ff);
      idx10 = CELL_W'(px1_ff + cz0_ff);
      idx01 = CELL_W'(px0_ff + cz0_ff + 8'd1);
      idx11 = CELL_W'(px1_ff + cz0_ff + 8'd1);
      h00   = perm_lookup(idx00);
      h10   = perm_lookup(idx10);
      h01   = perm_lookup(idx01);
      h11   = perm_lookup(idx11);
      grads_in.g00 = grad_type'(h00[2:0]);
      grads_in.g10 = grad_type'(h10[2:0]);
      grads_in.g01 = grad_type'(h01[2:0]);
      grads_in.g11 = grad_type'(h11[2:0]);
   end

   always_ff @(posedge clock) begin
      px0_ff   <= px0_in;
      px1_ff   <= px1_in;
      cz0_ff   <= cz0;
      grads_ff <= grads_in;
   end

   assign grads = grads_ff;

endmodule

`default_nettype wire

/* rtl/core/pn_lerp.sv */
// Two-stage linear blend a + rnd(w * (b - a)) in signed Q16.
`default_nettype none

module pn_lerp import pn_pkg::*; (
   input  logic     clock,
   input  dot_type  a,
   input  dot_type  b,
   input  fade_type w,
   output dot_type  y
);

   logic signed [DOT_W:0]        diff;
   logic signed [FADE_W:0]       w_s;
   logic signed [DOT_W+FADE_W+1:0] prod_ff, prod_in;
   logic signed [DOT_W+FADE_W+1:0] prod_rnd;
   dot_type                      a_ff;
   dot_type                      y_ff, y_in;

   // Weight the difference
   always_comb begin
      diff    = (DOT_W+1)'(b) - (DOT_W+1)'(a);
      w_s     = $signed({1'b0, w});
      prod_in = (DOT_W+FADE_W+2)'(w_s) * (DOT_W+FADE_W+2)'(diff);
   end

   // Round to Q16 and add back the base
   always_comb begin
      prod_rnd = prod_ff + (DOT_W+FADE_W+2)'(32768);
      y_in     = a_ff + DOT_W'(prod_rnd >>> 16);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a;
      y_ff    <= y_in;
   end

   assign y = y_ff;

endmodule

`default_nettype wire

/* rtl/core/pn_scale.sv */
// Two-stage scale by 1/sqrt(2), round to Q1.15 and clamp.
`default_nettype none

module pn_scale import pn_pkg::*; (
   input  logic      clock,
   input  dot_type   val,
   output noise_type noise
);

   localparam int PROD_W = DOT_W + FRAC_W + 1;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [PROD_W-1:0] res;
   noise_type                noise_ff, noise_in;

   // Multiply by the scale constant
   always_comb begin
      prod_in = PROD_W'(val) * PROD_W'(SCALE_Q16);
   end

   // Round to Q1.15 and saturate
   always_comb begin
      prod_rnd = prod_ff + PROD_W'(65536);
      res      = prod_rnd >>> 17;
      if (res > PROD_W'(32767)) begin
         noise_in = 16'sd32767;
      end else if (res < -PROD_W'(32768)) begin
         noise_in = -16'sd32768;
      end else begin
         noise_in = OUT_W'(res);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      noise_ff <= noise_in;
   end

   assign noise = noise_ff;

endmodule

`default_nettype wire

/* rtl/core/perlin_noise_2d.sv */
// Each accepted transaction yields one result, with rsp_valid raised alongside rsp_noise_value.
// Throughput: one point per cycle; busy stays low, so start may be high in every cycle.
// The depth is set by the fade multiplier chain (3 stages) and two blend levels and
// the scale (2 stages each) behind the input register.
// Reset clears the valid bits only; transactions in flight at reset are dropped.
`default_nettype none

module perlin_noise_2d import pn_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_z_coord,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_noise_value
);

   logic                 accept;
   logic [LATENCY-1:0]   valid_ff, valid_in;

   frac_type             fx_in, fz_in;
   frac_type             fx_ff, fz_ff;
   frac_type             fx_d1_ff, fz_d1_ff;
   frac_type             fx_d2_ff, fz_d2_ff;
   cell_type             cx_ff, cz_ff;

   fade_type             u_fade, v_fade;
   fade_type             v_d1_ff, v_d2_ff;
   corner_grad_type      grads;

   dot_type              dx0, dx1, dz0, dz1;
   dot_type              d00_ff, d10_ff, d01_ff, d11_ff;
   dot_type              d00_in, d10_in, d01_in, d11_in;
   dot_type              low_val, high_val, blend_val;

   // The pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Bring the fraction to Q0.16: truncate extra bits or pad with zeros
   if (COORD_FRAC_BITS >= FRAC_W) begin : g_frac_trunc
      assign fx_in = req_x_coord[COORD_FRAC_BITS-1 -: FRAC_W];
      assign fz_in = req_z_coord[COORD_FRAC_BITS-1 -: FRAC_W];
   end else begin : g_frac_pad
      assign fx_in = {req_x_coord[COORD_FRAC_BITS-1:0], {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
      assign fz_in = {req_z_coord[COORD_FRAC_BITS-1:0], {(FRAC_W-COORD_FRAC_BITS){1'b0}}};
   end

   // Capture the transaction: cell index and fraction
   always_ff @(posedge clock) begin
      cx_ff <= req_x_coord[COORD_FRAC_BITS +: CELL_W];
      cz_ff <= req_z_coord[COORD_FRAC_BITS +: CELL_W];
      fx_ff <= fx_in;
      fz_ff <= fz_in;
   end

   // Advance the valid bits with the data
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Fade weights along x and z
   pn_fade u_fade_x (
      .clock (clock),
      .t     (fx_ff),
      .fade  (u_fade)
   );

   pn_fade u_fade_z (
      .clock (clock),
      .t     (fz_ff),
      .fade  (v_fade)
   );

   // Corner gradients
   pn_hash u_hash (
      .clock (clock),
      .cx0   (cx_ff),
      .cz0   (cz_ff),
      .grads (grads)
   );

   // Hold the fractions until the gradient codes arrive
   always_ff @(posedge clock) begin
      fx_d1_ff <= fx_ff;
      fz_d1_ff <= fz_ff;
      fx_d2_ff <= fx_d1_ff;
      fz_d2_ff <= fz_d1_ff;
   end

   // Corner offsets and dot products
   always_comb begin
      dx0    = DOT_W'(fx_d2_ff);
      dz0    = DOT_W'(fz_d2_ff);
      dx1    = dx0 - DOT_W'(65536);
      dz1    = dz0 - DOT_W'(65536);
      d00_in = grad_dot(grads.g00, dx0, dz0);
      d10_in = grad_dot(grads.g10, dx1, dz0);
      d01_in = grad_dot(grads.g01, dx0, dz1);
      d11_in = grad_dot(grads.g11, dx1, dz1);
   end

   always_ff @(posedge clock) begin
      d00_ff <= d00_in;
      d10_ff <= d10_in;
      d01_ff <= d01_in;
      d11_ff <= d11_in;
   end

   // Blend along x
   pn_lerp u_lerp_low (
      .clock (clock),
      .a     (d00_ff),
      .b     (d10_ff),
      .w     (u_fade),
      .y     (low_val)
   );

   pn_lerp u_lerp_high (
      .clock (clock),
      .a     (d01_ff),
      .b     (d11_ff),
      .w     (u_fade),
      .y     (high_val)
   );

   // Hold the z weight while the x blend runs
   always_ff @(posedge clock) begin
      v_d1_ff <= v_fade;
      v_d2_ff <= v_d1_ff;
   end

   // Blend along z
   pn_lerp u_lerp_z (
      .clock (clock),
      .a     (low_val),
      .b     (high_val),
      .w     (v_d2_ff),
      .y     (blend_val)
   );

   // Scale, round and clamp into the output register
   pn_scale u_scale (
      .clock (clock),
      .val   (blend_val),
      .noise (rsp_noise_value)
   );

   assign rsp_valid = valid_ff[LATENCY-1];

endmodule

`default_nettype wire

/* rtl/core/pn_checker.sv */
// Port-level checks of the noise pipeline, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pn_checker import pn_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_x_coord,
   input logic signed [31:0] req_z_coord,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_noise_value
);

   logic corner_txn;

   // Flag an accepted transaction that sits exactly on a lattice corner
   assign corner_txn = start && !busy && req_x_coord[COORD_FRAC_BITS-1:0] == '0 &&
                       req_z_coord[COORD_FRAC_BITS-1:0] == '0;

   // The pipeline takes a transaction in every cycle
   `PN_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

   // Every accepted transaction yields one result after the fixed latency
   `PN_ASSERT_RST(a_result_follows, (start && !busy) |-> ##LATENCY rsp_valid, "result missing")

   // No result without a transaction accepted the same latency earlier
   `PN_ASSERT_RST(a_no_spurious, rsp_valid |-> $past(start && !busy, LATENCY), "spurious result")

   // A point on a lattice corner gives zero noise
   `PN_ASSERT_RST(a_corner_zero, corner_txn |-> ##LATENCY (rsp_noise_value == '0), "corner not zero")

endmodule

bind perlin_noise_2d pn_checker #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_pn_checker (.*);

`default_nettype wire

/* test/tb_perlin_noise_2d.sv */
// Self-checking testbench for the 2D gradient noise pipeline perlin_noise_2d.
`default_nettype none

module tb_perlin_noise_2d import pn_pkg::*;;

   localparam int FRAC_BITS     = 16;
   localparam int RANDOM_POINTS = 1400;
   localparam int QUIET_POINTS  = 400;    // random points sent with no idle cycles
   localparam int IDLE_PERCENT  = 7;
   localparam int MAX_REPORTS   = 10;

   // One point in flight and the noise value it must produce
   typedef struct {
      logic [31:0] x;
      logic [31:0] z;
      noise_type   noise;
   } noise_point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_z_coord = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_noise_value;

   noise_point_type pending_noise[$];
   int              fail_count = 0;
   bit              idle_on = 1'b1;

   // Cells whose four gradients all point toward the center, or all away from it
   bit              peak_found = 1'b0;
   bit              trough_found = 1'b0;
   cell_type        peak_cx, peak_cz, trough_cx, trough_cz;

   perlin_noise_2d #(
      .COORD_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_coord    (req_x_coord),
      .req_z_coord    (req_z_coord),
      .rsp_valid      (rsp_valid),
      .rsp_noise_value(rsp_noise_value)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Noise predictor
   // ------------------------------------------------------------------

   // Round to nearest, ties up: floor((v + 2^(sh-1)) / 2^sh)
   function automatic longint round_shift_q(input longint v, input int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   // Bring the coordinate fraction to unsigned Q0.16
   function automatic longint frac_q16(input logic [31:0] raw);
      longint f;
      f = longint'(raw & ((33'd1 << FRAC_BITS) - 1));
      if (FRAC_BITS >= 16) begin
         f = f >> (FRAC_BITS - 16);
      end else begin
         f = f << (16 - FRAC_BITS);
      end
      return f;
   endfunction

   // Quintic fade 6t^5 - 15t^4 + 10t^3 in Q16, capped at 1.0
   function automatic longint fade_weight(input longint t);
      longint sq, cube, poly, w;
      sq   = (t * t + 32768) >> 16;
      cube = (sq * t + 32768) >> 16;
      poly = 6 * sq + 655360 - 15 * t;
      w    = (cube * poly + 32768) >> 16;
      return (w > 65536) ? 65536 : w;
   endfunction

   // Gradient code of one corner from the two-level permutation hash
   function automatic grad_type corner_grad(input cell_type cx, input cell_type cz);
      cell_type h;
      h = PERM_ROM[cell_type'(PERM_ROM[cx] + cz)];
      return grad_type'(h[2:0]);
   endfunction

   function automatic longint corner_dot(input grad_type g, input longint dx,
                                         input longint dz);
      case (g)
         GRAD_PXPZ: return dx + dz;
         GRAD_NXPZ: return dz - dx;
         GRAD_PXNZ: return dx - dz;
         GRAD_NXNZ: return -dx - dz;
         GRAD_PX:   return dx;
         GRAD_NX:   return -dx;
         GRAD_PZ:   return dz;
         default:   return -dz;
      endcase
   endfunction

   function automatic longint lerp_q16(input longint a, input longint b, input longint w);
      return a + round_shift_q(w * (b - a), 16);
   endfunction

   function automatic noise_type noise_predict(input logic [31:0] xr, input logic [31:0] zr);
      cell_type cx0, cz0, cx1, cz1;
      longint   fx, fz, u, v, low, high, val, scaled;
      cx0 = cell_type'(xr >> FRAC_BITS);
      cz0 = cell_type'(zr >> FRAC_BITS);
      cx1 = cx0 + 8'd1;
      cz1 = cz0 + 8'd1;
      fx  = frac_q16(xr);
      fz  = frac_q16(zr);
      u   = fade_weight(fx);
      v   = fade_weight(fz);
      low  = lerp_q16(corner_dot(corner_grad(cx0, cz0), fx, fz),
                      corner_dot(corner_grad(cx1, cz0), fx - 65536, fz), u);
      high = lerp_q16(corner_dot(corner_grad(cx0, cz1), fx, fz - 65536),
                      corner_dot(corner_grad(cx1, cz1), fx - 65536, fz - 65536), u);
      val    = lerp_q16(low, high, v);
      scaled = round_shift_q(val * longint'(SCALE_Q16), 17);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      return noise_type'(scaled);
   endfunction

   // Replace cell and fraction fields of a coordinate; fraction given in Q0.16
   function automatic logic [31:0] make_coord(input logic [31:0] base, input cell_type c,
                                              input frac_type f);
      logic [31:0] field_mask, raw_frac;
      field_mask = (32'h100 << FRAC_BITS) - 1;
      if (FRAC_BITS >= 16) begin
         raw_frac = 32'(f) << (FRAC_BITS - 16);
      end else begin
         raw_frac = 32'(f) >> (16 - FRAC_BITS);
      end
      return (base & ~field_mask) | (32'(c) << FRAC_BITS) | raw_frac;
   endfunction

   // Search the lattice for a cell with the given four corner gradients
   function automatic bit find_cell(input grad_type g00, input grad_type g10,
                                    input grad_type g01, input grad_type g11,
                                    output cell_type cx, output cell_type cz);
      cx = '0;
      cz = '0;
      for (int i = 0; i < 256; i++) begin
         for (int j = 0; j < 256; j++) begin
            if (corner_grad(cell_type'(i), cell_type'(j)) == g00 &&
                corner_grad(cell_type'(i + 1), cell_type'(j)) == g10 &&
                corner_grad(cell_type'(i), cell_type'(j + 1)) == g01 &&
                corner_grad(cell_type'(i + 1), cell_type'(j + 1)) == g11) begin
               cx = cell_type'(i);
               cz = cell_type'(j);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Driver and checker
   // ------------------------------------------------------------------

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("ERROR: %s", msg);
      end
   endtask

   // Send one point, record its expected noise on acceptance, then maybe idle
   task automatic send_point(input logic [31:0] x, input logic [31:0] z);
      noise_point_type item;
      req_x_coord <= x;
      req_z_coord <= z;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      item.x     = x;
      item.z     = z;
      item.noise = noise_predict(x, z);
      pending_noise.insert(pending_noise.size(), item);
      @(negedge clock);
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Compare each result with the oldest pending transaction
   always @(posedge clock) begin : check_noise
      noise_point_type want;
      if (!reset && rsp_valid) begin
         if (pending_noise.size() == 0) begin
            note_failure($sformatf("result %0d with no transaction pending",
                                   rsp_noise_value));
         end else begin
            want = pending_noise.pop_front();
            if (rsp_noise_value !== want.noise) begin
               note_failure($sformatf("noise x=%h z=%h: expected %0d, got %0d",
                                      want.x, want.z, want.noise, rsp_noise_value));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Extremes of both coordinates, fraction ends and cell wraparound
   task automatic test_extremes;
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h0000_FFFF, 32'h0000_0000);
      send_point(32'h0000_8000, 32'h0000_8000);
      send_point(32'h00FF_FFFF, 32'h00FF_0000);
      send_point(32'hFFFF_0000, 32'h0001_0000);
      send_point(32'h5555_5555, 32'hAAAA_AAAA);
      send_point(32'hAAAA_AAAA, 32'h5555_5555);
      send_point(32'h00FF_8000, 32'hFFFF_8000);
   endtask

   // Every gradient code at the low corner, with random content elsewhere
   task automatic test_gradients;
      cell_type cx;
      for (int g = 0; g < 8; g++) begin
         cx = '0;
         for (int i = 0; i < 256; i++) begin
            if (corner_grad(cell_type'(i), 8'd0) == grad_type'(g)) begin
               cx = cell_type'(i);
               break;
            end
         end
         send_point(make_coord($urandom(), cx, frac_type'($urandom())),
                    make_coord($urandom(), 8'd0, frac_type'($urandom())));
      end
   endtask

   // Largest magnitudes: all gradients toward the cell center, then all away
   task automatic test_peak_cells;
      peak_found   = find_cell(GRAD_PXPZ, GRAD_NXPZ, GRAD_PXNZ, GRAD_NXNZ, peak_cx, peak_cz);
      trough_found = find_cell(GRAD_NXNZ, GRAD_PXNZ, GRAD_NXPZ, GRAD_PXPZ,
                               trough_cx, trough_cz);
      if (peak_found) begin
         send_point(make_coord(32'h0, peak_cx, 16'h8000),
                    make_coord(32'h0, peak_cz, 16'h8000));
         send_point(make_coord($urandom(), peak_cx,
                               frac_type'($urandom_range(16'h5000, 16'hB000))),
                    make_coord($urandom(), peak_cz,
                               frac_type'($urandom_range(16'h5000, 16'hB000))));
      end
      if (trough_found) begin
         send_point(make_coord(32'h0, trough_cx, 16'h8000),
                    make_coord(32'h0, trough_cz, 16'h8000));
         send_point(make_coord($urandom(), trough_cx,
                               frac_type'($urandom_range(16'h5000, 16'hB000))),
                    make_coord($urandom(), trough_cz,
                               frac_type'($urandom_range(16'h5000, 16'hB000))));
      end
   endtask

   // Random points: full range, near the origin, wrapping cells, fraction ends, peak and trough cells
   task automatic test_random;
      logic [31:0] x, z;
      frac_type    frac_ends[6];
      bit          use_peak;
      frac_ends = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         idle_on = (i >= QUIET_POINTS);
         case ($urandom_range(9))
            5, 6: begin
               x = $urandom_range(32'h0020_0000) - 32'h0010_0000;
               z = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            end
            7: begin
               x = make_coord($urandom(), $urandom_range(1) ? 8'hFF : 8'h00,
                              frac_type'($urandom()));
               z = make_coord($urandom(), $urandom_range(1) ? 8'hFF : 8'h00,
                              frac_type'($urandom()));
            end
            8: begin
               x = make_coord($urandom(), cell_type'($urandom()),
                              frac_ends[$urandom_range(5)]);
               z = make_coord($urandom(), cell_type'($urandom()),
                              frac_ends[$urandom_range(5)]);
            end
            9: begin
               use_peak = 1'($urandom_range(1));
               if (use_peak && peak_found) begin
                  x = make_coord($urandom(), peak_cx, frac_type'($urandom()));
                  z = make_coord($urandom(), peak_cz, frac_type'($urandom()));
               end else if (trough_found) begin
                  x = make_coord($urandom(), trough_cx, frac_type'($urandom()));
                  z = make_coord($urandom(), trough_cz, frac_type'($urandom()));
               end else begin
                  x = $urandom();
                  z = $urandom();
               end
            end
            default: begin
               x = $urandom();
               z = $urandom();
            end
         endcase
         send_point(x, z);
      end
   endtask

   // Drain the pipeline, check for leftovers and report
   task automatic finish_run;
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_noise.size() != 0 && waited < 20 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (pending_noise.size() != 0) begin
         note_failure($sformatf("%0d transactions never produced a result",
                                pending_noise.size()));
      end
      if (fail_count == 0) begin
         $display("tb_perlin_noise_2d: PASS");
      end else begin
         $display("tb_perlin_noise_2d: FAIL");
      end
      $finish;
   endtask

   // Hold reset, then run the tests in turn
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_gradients();
      test_peak_cells();
      test_random();
      finish_run();
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("tb_perlin_noise_2d: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
